### design/acm_pkg.sv
// Shared widths, pipeline layout and lookup functions for the accelerometer color/length block.
package acm_pkg;

   localparam int AxisW     = 16;
   localparam int MagW      = 8;
   localparam int AxisShift = 8;
   localparam int LevelW    = 8;
   localparam int NumW      = 15;
   localparam int SqW       = 15;
   localparam int SumW      = 16;
   localparam int LenIdxW   = 5;
   localparam int LenW      = 8;
   localparam int NumAxes   = 3;
   localparam int DivBits   = LevelW;
   localparam int StMag     = 0;
   localparam int StPre     = 1;
   localparam int StDiv     = 2;
   localparam int Depth     = StDiv + DivBits;

   typedef logic [MagW-1:0]   mag_type;
   typedef logic [NumW-1:0]   num_type;
   typedef logic [SqW-1:0]    sq_type;
   typedef logic [LevelW-1:0] level_type;
   typedef logic [LenW-1:0]   len_type;

   function automatic logic [LenIdxW-1:0] bit_len(input logic [SumW-1:0] v);
      logic [LenIdxW-1:0] n;
      n = '0;
      for (int i = 0; i < SumW; i++) begin
         if (v[i]) begin
            n = LenIdxW'(i + 1);
         end
      end
      return n;
   endfunction

   function automatic len_type length_lut(input logic [LenIdxW-1:0] idx);
      len_type r;
      case (idx)
         5'd0:    r = 8'd0;
         5'd1:    r = 8'd1;
         5'd2:    r = 8'd2;
         5'd3:    r = 8'd2;
         5'd4:    r = 8'd3;
         5'd5:    r = 8'd5;
         5'd6:    r = 8'd7;
         5'd7:    r = 8'd10;
         5'd8:    r = 8'd14;
         5'd9:    r = 8'd20;
         5'd10:   r = 8'd28;
         5'd11:   r = 8'd39;
         5'd12:   r = 8'd55;
         5'd13:   r = 8'd78;
         5'd14:   r = 8'd111;
         5'd15:   r = 8'd157;
         5'd16:   r = 8'd222;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

### design/accel_vector_color_magnitude.sv
// Top level: pipelined axis magnitude, color scaling divider and vector length lookup.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | req_accel_x, req_accel_y, req_accel_z
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_red/green/blue_level, rsp_length_estimate
//
// One transaction per cycle sustained while rsp_stall is low; the stages are magnitude, square/max,
// then one quotient bit per stage in an 8-stage restoring divider.
// Reset (synchronous) clears only the stage valid bits.
// Each stage holds while the stage after it is full and cannot move, so bubbles
// collapse and req_stall rises only when every stage is occupied.
module accel_vector_color_magnitude (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [acm_pkg::AxisW-1:0]    req_accel_x,
   input  logic signed [acm_pkg::AxisW-1:0]    req_accel_y,
   input  logic signed [acm_pkg::AxisW-1:0]    req_accel_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [acm_pkg::LevelW-1:0]   rsp_red_level,
   output logic        [acm_pkg::LevelW-1:0]   rsp_green_level,
   output logic        [acm_pkg::LevelW-1:0]   rsp_blue_level,
   output logic        [acm_pkg::LenW-1:0]     rsp_length_estimate
);

   localparam int Depth   = acm_pkg::Depth;
   localparam int DivBits = acm_pkg::DivBits;
   localparam int NumAxes = acm_pkg::NumAxes;
   localparam int StDiv   = acm_pkg::StDiv;

   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] adv;

   logic [acm_pkg::AxisW-1:0] axis_in [NumAxes];
   acm_pkg::mag_type          mag_in  [NumAxes];
   acm_pkg::mag_type          mag_ff  [NumAxes];

   acm_pkg::num_type          num_in  [NumAxes];
   acm_pkg::num_type          num_ff  [NumAxes];
   acm_pkg::sq_type           sq_in   [NumAxes];
   acm_pkg::sq_type           sq_ff   [NumAxes];
   acm_pkg::mag_type          max_in;
   acm_pkg::mag_type          max_ff;

   logic [acm_pkg::SumW-1:0]  sum_in;
   logic [acm_pkg::SumW-1:0]  sum_ff;

   acm_pkg::num_type          rem_src [DivBits][NumAxes];
   acm_pkg::level_type        quo_src [DivBits][NumAxes];
   acm_pkg::mag_type          dmax_src[DivBits];
   acm_pkg::num_type          trial   [DivBits];
   acm_pkg::num_type          rem_in  [DivBits][NumAxes];
   acm_pkg::level_type        quo_in  [DivBits][NumAxes];

   acm_pkg::num_type          rem_ff  [DivBits-1][NumAxes];
   acm_pkg::level_type        quo_ff  [DivBits-1][NumAxes];
   acm_pkg::mag_type          dmax_ff [DivBits-1];
   acm_pkg::len_type          len_ff  [DivBits-1];
   acm_pkg::level_type        lvl_ff  [NumAxes];

   // stage advance chain, output end first
   always_comb begin
      adv[Depth-1] = !valid_ff[Depth-1] || !rsp_stall;
      for (int i = Depth - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int i = 1; i < Depth; i++) begin
            if (adv[i]) begin
               valid_ff[i] <= valid_ff[i-1];
            end
         end
      end
   end

   // stage 0: |v| >> 8
   always_comb begin
      axis_in[0] = req_accel_x;
      axis_in[1] = req_accel_y;
      axis_in[2] = req_accel_z;
      for (int a = 0; a < NumAxes; a++) begin
         logic [acm_pkg::AxisW-1:0] absv;
         absv      = axis_in[a][acm_pkg::AxisW-1] ? (~axis_in[a] + 1'b1) : axis_in[a];
         mag_in[a] = absv[acm_pkg::AxisW-1 -: acm_pkg::MagW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[acm_pkg::StMag]) begin
         mag_ff <= mag_in;
      end
   end

   // stage 1: squares, numerators a*255, max
   always_comb begin
      max_in = mag_ff[0];
      for (int a = 0; a < NumAxes; a++) begin
         logic [2*acm_pkg::MagW-1:0] prod;
         prod      = mag_ff[a] * mag_ff[a];
         sq_in[a]  = acm_pkg::SqW'(prod);
         num_in[a] = (acm_pkg::NumW'(mag_ff[a]) << acm_pkg::LevelW)
                     - acm_pkg::NumW'(mag_ff[a]);
         if (mag_ff[a] > max_in) begin
            max_in = mag_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[acm_pkg::StPre]) begin
         num_ff <= num_in;
         sq_ff  <= sq_in;
         max_ff <= max_in;
      end
   end

   // restoring divider, one quotient bit per stage, MSB first
   always_comb begin
      sum_in = acm_pkg::SumW'(sq_ff[0]) + acm_pkg::SumW'(sq_ff[1])
               + acm_pkg::SumW'(sq_ff[2]);
      rem_src[0]  = num_ff;
      dmax_src[0] = max_ff;
      for (int a = 0; a < NumAxes; a++) begin
         quo_src[0][a] = '0;
      end
      for (int j = 1; j < DivBits; j++) begin
         rem_src[j]  = rem_ff[j-1];
         quo_src[j]  = quo_ff[j-1];
         dmax_src[j] = dmax_ff[j-1];
      end
      for (int j = 0; j < DivBits; j++) begin
         trial[j] = acm_pkg::NumW'(dmax_src[j]) << (DivBits - 1 - j);
         for (int a = 0; a < NumAxes; a++) begin
            if (rem_src[j][a] >= trial[j]) begin
               rem_in[j][a] = rem_src[j][a] - trial[j];
               quo_in[j][a] = {quo_src[j][a][acm_pkg::LevelW-2:0], 1'b1};
            end else begin
               rem_in[j][a] = rem_src[j][a];
               quo_in[j][a] = {quo_src[j][a][acm_pkg::LevelW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[StDiv]) begin
         sum_ff <= sum_in;
      end
      if (adv[StDiv+1]) begin
         len_ff[0] <= acm_pkg::length_lut(acm_pkg::bit_len(sum_ff));
      end
      for (int j = 0; j < DivBits - 1; j++) begin
         if (adv[StDiv+j]) begin
            rem_ff[j]  <= rem_in[j];
            quo_ff[j]  <= quo_in[j];
            dmax_ff[j] <= dmax_src[j];
         end
      end
      for (int j = 1; j < DivBits - 1; j++) begin
         if (adv[StDiv+j+1]) begin
            len_ff[j] <= len_ff[j-1];
         end
      end
      if (adv[Depth-1]) begin
         for (int a = 0; a < NumAxes; a++) begin
            lvl_ff[a] <= (dmax_src[DivBits-1] == '0) ? '0 : quo_in[DivBits-1][a];
         end
      end
   end

   assign rsp_red_level       = lvl_ff[0];
   assign rsp_green_level     = lvl_ff[1];
   assign rsp_blue_level      = lvl_ff[2];
   assign rsp_length_estimate = len_ff[DivBits-2];

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_ff[0])
      else $error("accepted transaction not captured in first stage");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled while pipeline has a free stage");

   a_peak_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_red_level == 8'd255 || rsp_green_level == 8'd255
                     || rsp_blue_level == 8'd255
                     || (rsp_red_level == 8'd0 && rsp_green_level == 8'd0
                         && rsp_blue_level == 8'd0 && rsp_length_estimate == 8'd0)))
      else $error("no axis at full level for nonzero vector");

endmodule

### verif/tb.sv
// Self-checking testbench for accel_vector_color_magnitude: predicted colors and length vs. DUT.
`timescale 1ns / 100ps

module tb;

   localparam int IdlePct    = 27;
   localparam int HoldCycles = 60;
   localparam int TailCycles = 20;
   localparam int CycleLimit = 200000;

   localparam logic [7:0] RootStep [0:16] = '{
      8'd0, 8'd1, 8'd2, 8'd2, 8'd3, 8'd5, 8'd7, 8'd10, 8'd14,
      8'd20, 8'd28, 8'd39, 8'd55, 8'd78, 8'd111, 8'd157, 8'd222
   };

   typedef struct packed {
      acm_pkg::level_type red;
      acm_pkg::level_type green;
      acm_pkg::level_type blue;
      acm_pkg::len_type   length;
   } color_result_type;

   class color_scoreboard;
      color_result_type expected_colors[$];
      int               mismatches = 0;
      int               checked    = 0;

      function acm_pkg::mag_type axis_mag(logic [acm_pkg::AxisW-1:0] raw);
         logic [acm_pkg::AxisW-1:0] v;
         v = raw[acm_pkg::AxisW-1] ? (~raw + 16'd1) : raw;
         return v[acm_pkg::AxisW-1:acm_pkg::AxisShift];
      endfunction

      function acm_pkg::level_type scale(acm_pkg::mag_type a, acm_pkg::mag_type m);
         int q;
         if (m == 0) return '0;
         q = (int'(a) * 255) / int'(m);
         return q[7:0];
      endfunction

      function void note_sample(logic [acm_pkg::AxisW-1:0] x, logic [acm_pkg::AxisW-1:0] y,
                                logic [acm_pkg::AxisW-1:0] z);
         acm_pkg::mag_type mx, my, mz, mmax;
         logic [16:0]      sum;
         logic [16:0]      t;
         int               nbits;
         color_result_type r;
         mx = axis_mag(x);
         my = axis_mag(y);
         mz = axis_mag(z);
         sum = 17'(mx) * 17'(mx) + 17'(my) * 17'(my) + 17'(mz) * 17'(mz);
         t = sum;
         nbits = 0;
         while (t != 0) begin
            t = t >> 1;
            nbits++;
         end
         if (nbits > 16) nbits = 16;
         mmax = mx;
         if (my > mmax) mmax = my;
         if (mz > mmax) mmax = mz;
         r.red    = scale(mx, mmax);
         r.green  = scale(my, mmax);
         r.blue   = scale(mz, mmax);
         r.length = RootStep[nbits];
         expected_colors.push_back(r);
      endfunction

      function void check_result(acm_pkg::level_type red, acm_pkg::level_type green,
                                 acm_pkg::level_type blue, acm_pkg::len_type length);
         color_result_type e;
         if (expected_colors.size() == 0) begin
            $error("unexpected result transaction: red %0d green %0d blue %0d length %0d",
                   red, green, blue, length);
            mismatches++;
            return;
         end
         e = expected_colors.pop_front();
         checked++;
         if (red !== e.red) begin
            $error("red_level mismatch: expected %0d, actual %0d", e.red, red);
            mismatches++;
         end
         if (green !== e.green) begin
            $error("green_level mismatch: expected %0d, actual %0d", e.green, green);
            mismatches++;
         end
         if (blue !== e.blue) begin
            $error("blue_level mismatch: expected %0d, actual %0d", e.blue, blue);
            mismatches++;
         end
         if (length !== e.length) begin
            $error("length_estimate mismatch: expected %0d, actual %0d", e.length, length);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_colors.size();
      endfunction
   endclass

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic signed [acm_pkg::AxisW-1:0] req_accel_x;
   logic signed [acm_pkg::AxisW-1:0] req_accel_y;
   logic signed [acm_pkg::AxisW-1:0] req_accel_z;
   logic                             rsp_valid;
   logic                             rsp_stall;
   acm_pkg::level_type               rsp_red_level;
   acm_pkg::level_type               rsp_green_level;
   acm_pkg::level_type               rsp_blue_level;
   acm_pkg::len_type                 rsp_length_estimate;

   color_scoreboard sb = new();
   bit quiet      = 1'b0;
   bit hold_out   = 1'b0;
   int sent       = 0;
   int stall_seen = 0;
   int cycles     = 0;

   accel_vector_color_magnitude DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_accel_x         (req_accel_x),
      .req_accel_y         (req_accel_y),
      .req_accel_z         (req_accel_z),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_red_level       (rsp_red_level),
      .rsp_green_level     (rsp_green_level),
      .rsp_blue_level      (rsp_blue_level),
      .rsp_length_estimate (rsp_length_estimate)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // result sink: random back-pressure, long hold on request
   initial begin : sink
      int n;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_out) begin
            rsp_stall = 1'b1;
            for (n = 0; n < HoldCycles; n++) @(negedge clock);
            hold_out  = 1'b0;
            rsp_stall = 1'b0;
         end else begin
            rsp_stall = !quiet && ($urandom_range(0, 99) < IdlePct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_red_level, rsp_green_level, rsp_blue_level,
                         rsp_length_estimate);
      if (!reset && req_valid && req_stall) stall_seen++;
   end

   function automatic logic [acm_pkg::AxisW-1:0] rand_axis();
      logic [acm_pkg::AxisW-1:0] v;
      case ($urandom_range(0, 9))
         5: begin
            case ($urandom_range(0, 7))
               0: v = 16'h8000;
               1: v = 16'h7FFF;
               2: v = 16'hFFFF;
               3: v = 16'hFF00;
               4: v = 16'hFF01;
               5: v = 16'h00FF;
               6: v = 16'h0100;
               default: v = 16'h0000;
            endcase
         end
         6: v = 16'($signed($urandom_range(0, 1023)) - 512);
         7: v = 16'h0000;
         8: v = {$urandom_range(0, 1) ? 8'h80 : 8'h7F, 8'($urandom)};
         9: v = {8'($urandom_range(0, 255)), 8'($urandom)};
         default: v = 16'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_sample(input logic [acm_pkg::AxisW-1:0] x,
                              input logic [acm_pkg::AxisW-1:0] y,
                              input logic [acm_pkg::AxisW-1:0] z);
      while (!quiet && $urandom_range(0, 99) < IdlePct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_accel_x = x;
      req_accel_y = y;
      req_accel_z = z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_sample(x, y, z);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_sample(rand_axis(), rand_axis(), rand_axis());
      req_valid = 1'b0;
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_accel_x = '0;
      req_accel_y = '0;
      req_accel_z = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed corners
      send_sample(16'h0000, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h8000);
      send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_sample(16'h8000, 16'h7FFF, 16'h0000);
      send_sample(16'hFFFF, 16'hFF01, 16'hFF00);
      send_sample(16'h00FF, 16'h0100, 16'hFEFF);
      send_sample(16'h0100, 16'h0000, 16'h0000);
      send_sample(16'h0000, 16'hFF00, 16'h0000);
      send_sample(16'h0000, 16'h0000, 16'h0200);
      send_sample(16'h0100, 16'h0100, 16'h0000);
      send_sample(16'h0100, 16'h0100, 16'h0100);
      send_sample(16'h8000, 16'h0000, 16'h0000);
      send_sample(16'h8000, 16'h8000, 16'h0000);
      send_sample(16'h8000, 16'h0100, 16'hFF00);
      send_sample(16'h7FFF, 16'h3FFF, 16'h0100);
      send_sample(16'hC000, 16'h4000, 16'hE000);
      send_sample(16'h0300, 16'hFD00, 16'h0700);
      send_sample(16'h0000, 16'h0000, 16'h8000);
      send_sample(16'h5A5A, 16'hA5A5, 16'hFFFF);
      send_sample(16'h0001, 16'h8001, 16'h7F00);
      req_valid = 1'b0;

      send_random(400);

      // back-pressure: sink holds while samples keep coming
      hold_out = 1'b1;
      quiet    = 1'b1;
      send_random(40);
      quiet = 1'b0;

      // sender pauses until the pipeline is empty
      drain();

      quiet = 1'b1;
      send_random(300);
      quiet = 1'b0;

      send_random(290);

      drain();
      repeat (TailCycles) @(negedge clock);

      $display("Sent %0d samples, checked %0d results, including corners and full-range axes.",
               sent, sb.checked);
      $display("Input stalled %0d cycles under back-pressure; %0d mismatches.",
               stall_seen, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

### sim.f
design/acm_pkg.sv
design/accel_vector_color_magnitude.sv
verif/tb.sv
